// ----- hdl/pwlock_pkg.sv -----
// Package for the password lock controller: phase, item kinds, codes and result word.
package pwlock_pkg;

   // Lock phase
   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_SET_FIRST  = 4'd1,
      PH_SET_SECOND = 4'd2,
      PH_OPEN_ENTRY = 4'd3,
      PH_UNLOCKING  = 4'd4,
      PH_POLLING    = 4'd5,
      PH_CLOSING    = 4'd6,
      PH_CHG_OLD    = 4'd7,
      PH_CHG_FIRST  = 4'd8,
      PH_CHG_SECOND = 4'd9,
      PH_ALARM      = 4'd10
   } phase_type;

   // Kind of input word, carried on tuser
   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_MOTION = 2'd2
   } kind_type;

   // Command codes received over the link
   localparam logic [7:0] CMD_SET    = 8'd1;
   localparam logic [7:0] CMD_OPEN   = 8'd2;
   localparam logic [7:0] CMD_CHANGE = 8'd3;
   localparam logic [7:0] CMD_ALARM  = 8'd4;

   // Motor drive codes
   localparam logic [1:0] MOTOR_STOP    = 2'd0;
   localparam logic [1:0] MOTOR_FORWARD = 2'd1;
   localparam logic [1:0] MOTOR_REVERSE = 2'd2;

   // Configuration register indexes
   localparam logic CSR_UNLOCK_SECONDS = 1'b0;
   localparam logic CSR_ALARM_SECONDS  = 1'b1;

   // Register reset values
   localparam logic [7:0] UNLOCK_SECONDS_RST = 8'd15;
   localparam logic [7:0] ALARM_SECONDS_RST  = 8'd60;

   localparam logic [7:0] TICK_MAX = 8'd255;

   // Result word, tx_valid in the lowest bit
   typedef struct packed {
      logic       alarm_sound;
      logic [1:0] motor_drive;
      logic       reply;
      logic       tx_valid;
   } rsp_word_type;

endpackage

// ----- hdl/password_lock_controller.sv -----
// Password lock controller: command parser, password store, motor and buzzer timing.
//
//  channel  dir  handshake          payload
//  req_     in   tvalid/tready      tdata: rx_byte, motion; tuser: word kind
//  rsp_     out  tvalid/tready      tdata: tx_valid, reply, motor_drive, alarm_sound; tlast
//  csr_     in   we only            addr: register index; wdata: register value
//
// One word is taken per cycle unless the input stalls; the state is updated and its results are
// registered at the edge that accepts it. A motion sample that reads nobody
// present yields two results; the second waits in a holding register and
// req_tready is low until it has moved on to the result register.
// Reset is synchronous; the stored password clears to zeros at once.
// While a result word waits on rsp_tready, req_tready is low and the input stalls.
module password_lock_controller #(
   parameter int PASSWORD_BYTES = 5
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [8] motion, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] word kind
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] tx_valid, [1] reply, [3:2] motor_drive, [4] alarm_sound
   output logic        rsp_tlast
);
   import pwlock_pkg::*;

   localparam int CNT_W = $clog2(PASSWORD_BYTES + 1);
   localparam int IDX_W = (PASSWORD_BYTES > 1) ? $clog2(PASSWORD_BYTES) : 1;
   localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(PASSWORD_BYTES - 1);

   // configuration registers
   logic [7:0] unlock_seconds_ff;
   logic [7:0] alarm_seconds_ff;

   // lock state
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] digit_index_ff, digit_index_in;
   logic             mismatch_seen_ff, mismatch_seen_in;
   logic [7:0]       elapsed_ticks_ff, elapsed_ticks_in;
   logic [7:0]       entry_buffer_ff [PASSWORD_BYTES];
   logic [7:0]       stored_password_ff [PASSWORD_BYTES];

   // result register and holding register for a second result
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   logic         out_last_ff;
   logic         pend_valid_ff;
   rsp_word_type pend_word_ff;

   // decoded input word
   logic             accept;
   kind_type         kind;
   logic [7:0]       rx_byte;
   logic             motion;
   logic [IDX_W-1:0] idx;
   logic             last_digit;
   logic [7:0]       tick_count;
   logic [7:0]       unlock_limit;
   logic [7:0]       alarm_limit;
   logic             buf_write;
   logic             pw_copy;
   logic             entry_diff;
   logic             stored_diff;

   // results of this word
   logic         r0_tx, r0_reply, r0_last, r0_poll_levels;
   logic         r1_valid;
   rsp_word_type r0_word;
   rsp_word_type r1_word;

   logic out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !pend_valid_ff && out_free;
   assign accept     = req_tvalid && req_tready;

   assign kind        = kind_type'(req_tuser);
   assign rx_byte     = req_tdata[7:0];
   assign motion      = req_tdata[8];
   assign idx         = digit_index_ff[IDX_W-1:0];
   assign last_digit  = (digit_index_ff == LAST_DIGIT);
   assign entry_diff  = (rx_byte != entry_buffer_ff[idx]);
   assign stored_diff = (rx_byte != stored_password_ff[idx]);

   // saturating tick count and zero-as-one limits
   assign tick_count   = (elapsed_ticks_ff == TICK_MAX) ? TICK_MAX : elapsed_ticks_ff + 8'd1;
   assign unlock_limit = (unlock_seconds_ff == 8'd0) ? 8'd1 : unlock_seconds_ff;
   assign alarm_limit  = (alarm_seconds_ff == 8'd0) ? 8'd1 : alarm_seconds_ff;

   // next state and results for the word on the input
   always_comb begin
      phase_in         = phase_ff;
      digit_index_in   = digit_index_ff;
      mismatch_seen_in = mismatch_seen_ff;
      elapsed_ticks_in = elapsed_ticks_ff;
      buf_write        = 1'b0;
      pw_copy          = 1'b0;
      r0_tx            = 1'b0;
      r0_reply         = 1'b0;
      r0_last          = 1'b1;
      r0_poll_levels   = 1'b0;
      r1_valid         = 1'b0;

      unique case (kind)
         KIND_BYTE: begin
            unique case (phase_ff)
               PH_IDLE: begin
                  priority if (rx_byte == CMD_SET) begin
                     phase_in         = PH_SET_FIRST;
                     digit_index_in   = '0;
                     mismatch_seen_in = 1'b0;
                  end else if (rx_byte == CMD_OPEN) begin
                     phase_in         = PH_OPEN_ENTRY;
                     digit_index_in   = '0;
                     mismatch_seen_in = 1'b0;
                  end else if (rx_byte == CMD_CHANGE) begin
                     phase_in         = PH_CHG_OLD;
                     digit_index_in   = '0;
                     mismatch_seen_in = 1'b0;
                  end else if (rx_byte == CMD_ALARM) begin
                     phase_in         = PH_ALARM;
                     elapsed_ticks_in = '0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_SET_FIRST, PH_CHG_FIRST: begin
                  buf_write      = 1'b1;
                  digit_index_in = digit_index_ff + CNT_W'(1);
                  if (last_digit) begin
                     phase_in         = (phase_ff == PH_SET_FIRST) ? PH_SET_SECOND
                                                                   : PH_CHG_SECOND;
                     digit_index_in   = '0;
                     mismatch_seen_in = 1'b0;
                  end
               end
               PH_SET_SECOND, PH_CHG_SECOND: begin
                  mismatch_seen_in = mismatch_seen_ff | entry_diff;
                  digit_index_in   = digit_index_ff + CNT_W'(1);
                  if (last_digit) begin
                     pw_copy        = !mismatch_seen_in;
                     phase_in       = PH_IDLE;
                     digit_index_in = '0;
                     r0_tx          = 1'b1;
                     r0_reply       = !mismatch_seen_in;
                  end
               end
               PH_OPEN_ENTRY, PH_CHG_OLD: begin
                  mismatch_seen_in = mismatch_seen_ff | stored_diff;
                  digit_index_in   = digit_index_ff + CNT_W'(1);
                  if (last_digit) begin
                     r0_tx          = 1'b1;
                     r0_reply       = !mismatch_seen_in;
                     digit_index_in = '0;
                     priority if (mismatch_seen_in) begin
                        phase_in = PH_IDLE;
                     end else if (phase_ff == PH_OPEN_ENTRY) begin
                        phase_in         = PH_UNLOCKING;
                        elapsed_ticks_in = '0;
                     end else begin
                        phase_in         = PH_CHG_FIRST;
                        mismatch_seen_in = 1'b0;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         KIND_TICK: begin
            unique case (phase_ff)
               PH_UNLOCKING: begin
                  elapsed_ticks_in = tick_count;
                  if (tick_count >= unlock_limit) phase_in = PH_POLLING;
               end
               PH_CLOSING: begin
                  elapsed_ticks_in = tick_count;
                  if (tick_count >= unlock_limit) phase_in = PH_IDLE;
               end
               PH_ALARM: begin
                  elapsed_ticks_in = tick_count;
                  if (tick_count >= alarm_limit) phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         KIND_MOTION: begin
            if (phase_ff == PH_POLLING) begin
               r0_tx          = 1'b1;
               r0_reply       = 1'b1;
               r0_last        = motion;
               r0_poll_levels = 1'b1;
               if (!motion) begin
                  phase_in         = PH_CLOSING;
                  elapsed_ticks_in = '0;
                  r1_valid         = 1'b1;
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // result words: levels follow the phase in force when each is sent
   always_comb begin
      r0_word.tx_valid    = r0_tx;
      r0_word.reply       = r0_reply;
      r0_word.motor_drive = MOTOR_STOP;
      r0_word.alarm_sound = 1'b0;
      if (!r0_poll_levels) begin
         r0_word.alarm_sound = (phase_in == PH_ALARM);
         if (phase_in == PH_UNLOCKING) r0_word.motor_drive = MOTOR_FORWARD;
         else if (phase_in == PH_CLOSING) r0_word.motor_drive = MOTOR_REVERSE;
      end
      r1_word.tx_valid    = 1'b1;
      r1_word.reply       = 1'b0;
      r1_word.motor_drive = MOTOR_REVERSE;
      r1_word.alarm_sound = 1'b0;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_seconds_ff <= UNLOCK_SECONDS_RST;
         alarm_seconds_ff  <= ALARM_SECONDS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_UNLOCK_SECONDS: unlock_seconds_ff <= csr_wdata;
            CSR_ALARM_SECONDS:  alarm_seconds_ff  <= csr_wdata;
            default:            unlock_seconds_ff <= unlock_seconds_ff;
         endcase
      end
   end

   // lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         digit_index_ff   <= '0;
         mismatch_seen_ff <= 1'b0;
         elapsed_ticks_ff <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         digit_index_ff   <= digit_index_in;
         mismatch_seen_ff <= mismatch_seen_in;
         elapsed_ticks_ff <= elapsed_ticks_in;
      end
   end

   // entry buffer, written one digit at a time
   always_ff @(posedge clock) begin
      if (accept && buf_write) entry_buffer_ff[idx] <= rx_byte;
   end

   // stored password, copied whole from the entry buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PASSWORD_BYTES; i++) stored_password_ff[i] <= '0;
      end else if (accept && pw_copy) begin
         for (int i = 0; i < PASSWORD_BYTES; i++) stored_password_ff[i] <= entry_buffer_ff[i];
      end
   end

   // result register and holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff  <= 1'b1;
         out_word_ff   <= r0_word;
         out_last_ff   <= r0_last;
         pend_valid_ff <= r1_valid;
         pend_word_ff  <= r1_word;
      end else if (out_free) begin
         out_valid_ff  <= pend_valid_ff;
         out_word_ff   <= pend_word_ff;
         out_last_ff   <= 1'b1;
         pend_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_word_ff};
   assign rsp_tlast  = out_last_ff;

   // a queued second result always sits behind a first one
   assert property (@(posedge clock) disable iff (reset) pend_valid_ff |-> out_valid_ff)
      else $error("held result without a result in front");

   // a non-final result always has its follower queued
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> pend_valid_ff)
      else $error("non-final result with nothing behind it");

   // the digit counter stays inside the password
   assert property (@(posedge clock) disable iff (reset) digit_index_ff <= LAST_DIGIT)
      else $error("digit index beyond password length");

   // motor and buzzer never run together
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_word_ff.alarm_sound && (out_word_ff.motor_drive != MOTOR_STOP)))
      else $error("buzzer and motor active together");

   // a nobody-present sample in polling leaves the second result queued
   assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_MOTION && phase_ff == PH_POLLING && !motion)
      |=> (pend_valid_ff && phase_ff == PH_CLOSING))
      else $error("closing result not queued");

endmodule
